>>> rtl/tbc_pkg.sv
// shared constants for the triangle barycentric weight pipeline
// no dependencies; used by triangle_barycentric_coords_top
package tbc_pkg;

    localparam int COORD_WIDTH_DEF      = 32;
    localparam int WEIGHT_FRAC_BITS_DEF = 24;
    localparam int WEIGHT_W             = 32;
    localparam int QUOT_BITS            = 32;

    // stage ordering of the pipeline
    localparam int ST_IN    = 0;
    localparam int ST_NPROD = 1;
    localparam int ST_NDET  = 2;
    localparam int ST_NABS  = 3;
    localparam int ST_PROJ  = 4;
    localparam int ST_WPROD = 5;
    localparam int ST_WDET  = 6;
    localparam int ST_WABS  = 7;
    localparam int ST_DINIT = 8;
    localparam int ST_DIV0  = 9;
    localparam int ST_SAT   = ST_DIV0 + QUOT_BITS;
    localparam int ST_OUT   = ST_SAT + 1;
    localparam int N_STAGES = ST_OUT + 1;

endpackage

>>> rtl/triangle_barycentric_coords_top.sv
// barycentric weights of a point against a 3d triangle, fully pipelined
// one beat per cycle sustained while the output is not stalled
// the whole pipe advances together; a stalled output holds every stage
// the 32 one-bit restoring divider stages set the depth
// reset (i_rst_n low, synchronous) clears all stage valid bits
// depends on tbc_pkg
module triangle_barycentric_coords_top #(
    parameter int COORD_WIDTH      = tbc_pkg::COORD_WIDTH_DEF,
    parameter int WEIGHT_FRAC_BITS = tbc_pkg::WEIGHT_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_vertex0_x,
    input  logic signed [COORD_WIDTH-1:0] i_vertex0_y,
    input  logic signed [COORD_WIDTH-1:0] i_vertex0_z,
    input  logic signed [COORD_WIDTH-1:0] i_vertex1_x,
    input  logic signed [COORD_WIDTH-1:0] i_vertex1_y,
    input  logic signed [COORD_WIDTH-1:0] i_vertex1_z,
    input  logic signed [COORD_WIDTH-1:0] i_vertex2_x,
    input  logic signed [COORD_WIDTH-1:0] i_vertex2_y,
    input  logic signed [COORD_WIDTH-1:0] i_vertex2_z,
    input  logic signed [COORD_WIDTH-1:0] i_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_y,
    input  logic signed [COORD_WIDTH-1:0] i_point_z,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [tbc_pkg::WEIGHT_W-1:0] o_weight0,
    output logic signed [tbc_pkg::WEIGHT_W-1:0] o_weight1,
    output logic signed [tbc_pkg::WEIGHT_W-1:0] o_weight2,
    output logic                          o_degenerate
);

    localparam int W   = COORD_WIDTH;
    localparam int EW  = W + 1;
    localparam int PW  = 2 * W + 2;
    localparam int DW  = 2 * W + 3;
    localparam int MW  = DW;
    localparam int QB  = tbc_pkg::QUOT_BITS;
    localparam int RW  = MW + QB + 1;
    localparam int OW  = tbc_pkg::WEIGHT_W;
    localparam int SW  = OW + 2;
    localparam int NS  = tbc_pkg::N_STAGES;

    localparam logic signed [OW-1:0] W_MAX = {1'b0, {(OW-1){1'b1}}};
    localparam logic signed [OW-1:0] W_MIN = {1'b1, {(OW-1){1'b0}}};
    localparam logic signed [SW-1:0] W_ONE = SW'(1) <<< WEIGHT_FRAC_BITS;

    logic          en;
    logic [NS-1:0] r_vld;

    assign en      = !r_vld[NS-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    // stage in: coordinates and edges
    logic signed [W-1:0]  n_c [12];
    logic signed [W-1:0]  r_c0 [12];
    logic signed [EW-1:0] r_e1 [3];
    logic signed [EW-1:0] r_e2 [3];

    always_comb begin
        n_c[0]  = i_vertex0_x; n_c[1]  = i_vertex0_y; n_c[2]  = i_vertex0_z;
        n_c[3]  = i_vertex1_x; n_c[4]  = i_vertex1_y; n_c[5]  = i_vertex1_z;
        n_c[6]  = i_vertex2_x; n_c[7]  = i_vertex2_y; n_c[8]  = i_vertex2_z;
        n_c[9]  = i_point_x;   n_c[10] = i_point_y;   n_c[11] = i_point_z;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c0 <= n_c;
            for (int j = 0; j < 3; j++) begin
                r_e1[j] <= EW'(n_c[3 + j]) - EW'(n_c[j]);
                r_e2[j] <= EW'(n_c[6 + j]) - EW'(n_c[j]);
            end
        end
    end

    // normal products
    logic signed [W-1:0]  r_c1 [12];
    logic signed [PW-1:0] r_np [6];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c1     <= r_c0;
            r_np[0]  <= r_e1[1] * r_e2[2];
            r_np[1]  <= r_e1[2] * r_e2[1];
            r_np[2]  <= r_e1[2] * r_e2[0];
            r_np[3]  <= r_e1[0] * r_e2[2];
            r_np[4]  <= r_e1[0] * r_e2[1];
            r_np[5]  <= r_e1[1] * r_e2[0];
        end
    end

    // normal components
    logic signed [W-1:0]  r_c2 [12];
    logic signed [DW-1:0] r_n [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c2 <= r_c1;
            for (int j = 0; j < 3; j++) begin
                r_n[j] <= DW'(r_np[2 * j]) - DW'(r_np[2 * j + 1]);
            end
        end
    end

    // normal magnitudes
    logic signed [W-1:0] r_c3 [12];
    logic [MW-1:0]       r_na [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c3 <= r_c2;
            for (int j = 0; j < 3; j++) begin
                r_na[j] <= r_n[j][DW-1] ? MW'(-r_n[j]) : MW'(r_n[j]);
            end
        end
    end

    // drop the dominant axis and form projected differences
    logic [1:0]           ua;
    logic [1:0]           va;
    logic signed [W-1:0]  a [4];
    logic signed [W-1:0]  b [4];
    logic signed [EW-1:0] r_u [4];
    logic signed [EW-1:0] r_v [4];

    always_comb begin
        if (r_na[0] >= r_na[1] && r_na[0] >= r_na[2]) begin
            ua = 2'd1; va = 2'd2;
        end else if (r_na[1] >= r_na[2]) begin
            ua = 2'd2; va = 2'd0;
        end else begin
            ua = 2'd0; va = 2'd1;
        end
        for (int k = 0; k < 4; k++) begin
            a[k] = r_c3[k * 3 + int'(ua)];
            b[k] = r_c3[k * 3 + int'(va)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_u[0] <= EW'(a[0]) - EW'(a[2]);
            r_u[1] <= EW'(a[1]) - EW'(a[2]);
            r_u[2] <= EW'(a[3]) - EW'(a[0]);
            r_u[3] <= EW'(a[3]) - EW'(a[2]);
            r_v[0] <= EW'(b[0]) - EW'(b[2]);
            r_v[1] <= EW'(b[1]) - EW'(b[2]);
            r_v[2] <= EW'(b[3]) - EW'(b[0]);
            r_v[3] <= EW'(b[3]) - EW'(b[2]);
        end
    end

    // weight products: den pair, num0 pair, num1 pair
    logic signed [PW-1:0] r_wp [6];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wp[0] <= r_v[0] * r_u[1];
            r_wp[1] <= r_v[1] * r_u[0];
            r_wp[2] <= r_v[3] * r_u[1];
            r_wp[3] <= r_v[1] * r_u[3];
            r_wp[4] <= r_v[0] * r_u[2];
            r_wp[5] <= r_v[2] * r_u[0];
        end
    end

    logic signed [DW-1:0] r_den;
    logic signed [DW-1:0] r_num0;
    logic signed [DW-1:0] r_num1;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_den  <= DW'(r_wp[0]) - DW'(r_wp[1]);
            r_num0 <= DW'(r_wp[2]) - DW'(r_wp[3]);
            r_num1 <= DW'(r_wp[4]) - DW'(r_wp[5]);
        end
    end

    // magnitudes and signs
    logic [MW-1:0] r_dmag;
    logic [MW-1:0] r_nmag0;
    logic [MW-1:0] r_nmag1;
    logic          r_neg0_a;
    logic          r_neg1_a;
    logic          r_degen_a;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dmag    <= r_den[DW-1]  ? MW'(-r_den)  : MW'(r_den);
            r_nmag0   <= r_num0[DW-1] ? MW'(-r_num0) : MW'(r_num0);
            r_nmag1   <= r_num1[DW-1] ? MW'(-r_num1) : MW'(r_num1);
            r_neg0_a  <= r_num0[DW-1] ^ r_den[DW-1];
            r_neg1_a  <= r_num1[DW-1] ^ r_den[DW-1];
            r_degen_a <= (r_den == '0);
        end
    end

    // divider pipe, entry 0 is the setup stage
    logic [RW-1:0] r_rem0 [QB+1];
    logic [RW-1:0] r_rem1 [QB+1];
    logic [MW-1:0] r_dd   [QB+1];
    logic [QB-1:0] r_q0   [QB+1];
    logic [QB-1:0] r_q1   [QB+1];
    logic          r_ovf0 [QB+1];
    logic          r_ovf1 [QB+1];
    logic          r_neg0 [QB+1];
    logic          r_neg1 [QB+1];
    logic          r_dgn  [QB+1];

    logic [RW-1:0] num0_sh;
    logic [RW-1:0] num1_sh;
    logic [RW-1:0] den_cap;

    assign num0_sh = RW'(r_nmag0) << WEIGHT_FRAC_BITS;
    assign num1_sh = RW'(r_nmag1) << WEIGHT_FRAC_BITS;
    assign den_cap = RW'(r_dmag) << QB;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rem0[0] <= num0_sh;
            r_rem1[0] <= num1_sh;
            r_dd[0]   <= r_dmag;
            r_q0[0]   <= '0;
            r_q1[0]   <= '0;
            // quotient would reach 2^32: saturates whatever the sign
            r_ovf0[0] <= (num0_sh >= den_cap);
            r_ovf1[0] <= (num1_sh >= den_cap);
            r_neg0[0] <= r_neg0_a;
            r_neg1[0] <= r_neg1_a;
            r_dgn[0]  <= r_degen_a;
        end
    end

    for (genvar j = 0; j < QB; j++) begin : g_div
        localparam int SH = QB - 1 - j;
        logic [RW-1:0] dsh;
        logic          ge0;
        logic          ge1;

        assign dsh = RW'(r_dd[j]) << SH;
        assign ge0 = (r_rem0[j] >= dsh);
        assign ge1 = (r_rem1[j] >= dsh);

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rem0[j+1] <= ge0 ? r_rem0[j] - dsh : r_rem0[j];
                r_rem1[j+1] <= ge1 ? r_rem1[j] - dsh : r_rem1[j];
                r_q0[j+1]   <= {r_q0[j][QB-2:0], ge0};
                r_q1[j+1]   <= {r_q1[j][QB-2:0], ge1};
                r_dd[j+1]   <= r_dd[j];
                r_ovf0[j+1] <= r_ovf0[j];
                r_ovf1[j+1] <= r_ovf1[j];
                r_neg0[j+1] <= r_neg0[j];
                r_neg1[j+1] <= r_neg1[j];
                r_dgn[j+1]  <= r_dgn[j];
            end
        end
    end

    // signed saturation of the two quotients
    logic signed [OW-1:0] r_w0;
    logic signed [OW-1:0] r_w1;
    logic                 r_dgn_s;

    function automatic logic signed [OW-1:0] sat_q(
        input logic [QB-1:0] q,
        input logic          ovf,
        input logic          neg
    );
        logic big;
        big = ovf || q[QB-1];
        if (neg) begin
            sat_q = big ? W_MIN : -$signed(OW'(q));
        end else begin
            sat_q = big ? W_MAX : $signed(OW'(q));
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w0    <= sat_q(r_q0[QB], r_ovf0[QB], r_neg0[QB]);
            r_w1    <= sat_q(r_q1[QB], r_ovf1[QB], r_neg1[QB]);
            r_dgn_s <= r_dgn[QB];
        end
    end

    // third weight and output register
    logic signed [SW-1:0] w2_full;
    logic signed [OW-1:0] w2_sat;

    assign w2_full = W_ONE - SW'(r_w0) - SW'(r_w1);

    always_comb begin
        if (w2_full > SW'(W_MAX)) begin
            w2_sat = W_MAX;
        end else if (w2_full < SW'(W_MIN)) begin
            w2_sat = W_MIN;
        end else begin
            w2_sat = OW'(w2_full);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_weight0    <= r_dgn_s ? '0 : r_w0;
            o_weight1    <= r_dgn_s ? '0 : r_w1;
            o_weight2    <= r_dgn_s ? '0 : w2_sat;
            o_degenerate <= r_dgn_s;
        end
    end

endmodule

>>> sim/tb_triangle_barycentric_coords_top.sv
// self-checking testbench for triangle_barycentric_coords_top: barycentric weights
// compared beat by beat against an exact wide-integer predictor
// depends on rtl/tbc_pkg.sv and rtl/triangle_barycentric_coords_top.sv
`timescale 1ns / 1ps

typedef logic signed [31:0] coord_t;
typedef coord_t tri_query_t [12];

typedef struct {
    logic signed [31:0] w0;
    logic signed [31:0] w1;
    logic signed [31:0] w2;
    logic               degen;
} weights_t;

class weight_scoreboard;
    weights_t pending[$];
    int       n_checked;
    int       n_errors;
    int       n_degen;
    int       n_sat;

    function automatic logic signed [31:0] clamp32(logic signed [127:0] v);
        if (v > 128'sd2147483647) return 32'sh7fffffff;
        if (v < -128'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // exact projected 2d solve, all intermediates held in 128-bit signed
    function automatic weights_t solve_weights(tri_query_t c);
        logic signed [127:0] p[4][3];
        logic signed [127:0] e1[3], e2[3];
        logic signed [127:0] nx, ny, nz, den, num0, num1, w2;
        logic signed [127:0] u1, u2, u3, u4, v1, v2, v3, v4;
        int ua, va;
        weights_t r;
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 3; j++)
                p[i][j] = c[i*3+j];
        for (int j = 0; j < 3; j++) begin
            e1[j] = p[1][j] - p[0][j];
            e2[j] = p[2][j] - p[0][j];
        end
        nx = e1[1]*e2[2] - e1[2]*e2[1];
        ny = e1[2]*e2[0] - e1[0]*e2[2];
        nz = e1[0]*e2[1] - e1[1]*e2[0];
        if (nx < 0) nx = -nx;
        if (ny < 0) ny = -ny;
        if (nz < 0) nz = -nz;
        // drop the dominant normal axis, ties favor x then y
        if (nx >= ny && nx >= nz) begin
            ua = 1; va = 2;
        end else if (ny >= nz) begin
            ua = 2; va = 0;
        end else begin
            ua = 0; va = 1;
        end
        u1 = p[0][ua] - p[2][ua];  v1 = p[0][va] - p[2][va];
        u2 = p[1][ua] - p[2][ua];  v2 = p[1][va] - p[2][va];
        u3 = p[3][ua] - p[0][ua];  v3 = p[3][va] - p[0][va];
        u4 = p[3][ua] - p[2][ua];  v4 = p[3][va] - p[2][va];
        den  = v1*u2 - v2*u1;
        num0 = v4*u2 - v2*u4;
        num1 = v1*u3 - v3*u1;
        if (den == 0) begin
            r.w0 = '0; r.w1 = '0; r.w2 = '0; r.degen = 1'b1;
            return r;
        end
        // signed division truncates toward zero
        r.w0 = clamp32((num0 <<< 24) / den);
        r.w1 = clamp32((num1 <<< 24) / den);
        w2 = (128'sd1 <<< 24) - 128'(r.w0) - 128'(r.w1);
        r.w2 = clamp32(w2);
        r.degen = 1'b0;
        return r;
    endfunction

    function void note_query(tri_query_t c);
        weights_t e;
        e = solve_weights(c);
        if (e.degen) n_degen++;
        if (e.w0 == 32'sh7fffffff || e.w0 == 32'sh80000000 ||
            e.w1 == 32'sh7fffffff || e.w1 == 32'sh80000000) n_sat++;
        pending.push_back(e);
    endfunction

    function void check_weights(weights_t got);
        weights_t e;
        if (pending.size() == 0) begin
            n_errors++;
            if (n_errors <= 10)
                $display("unexpected result beat: w0=%h w1=%h w2=%h degen=%b",
                         got.w0, got.w1, got.w2, got.degen);
            return;
        end
        e = pending.pop_front();
        n_checked++;
        if (e.w0 !== got.w0 || e.w1 !== got.w1 || e.w2 !== got.w2 ||
            e.degen !== got.degen) begin
            n_errors++;
            if (n_errors <= 10)
                $display("mismatch #%0d: exp w0=%h w1=%h w2=%h dg=%b got w0=%h w1=%h w2=%h dg=%b",
                         n_checked, e.w0, e.w1, e.w2, e.degen,
                         got.w0, got.w1, got.w2, got.degen);
        end
    endfunction
endclass

module tb_triangle_barycentric_coords_top;

    localparam coord_t ONE = 32'sh0001_0000;

    logic   i_clk;
    logic   i_rst_n;
    logic   i_valid;
    logic   o_ready;
    coord_t i_vertex0_x, i_vertex0_y, i_vertex0_z;
    coord_t i_vertex1_x, i_vertex1_y, i_vertex1_z;
    coord_t i_vertex2_x, i_vertex2_y, i_vertex2_z;
    coord_t i_point_x, i_point_y, i_point_z;
    logic   o_valid;
    logic   i_ready;
    logic signed [tbc_pkg::WEIGHT_W-1:0] o_weight0, o_weight1, o_weight2;
    logic   o_degenerate;

    weight_scoreboard sb;
    int snd_idle_pct;
    int rcv_idle_pct;
    int n_sent;

    triangle_barycentric_coords_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_vertex0_x(i_vertex0_x), .i_vertex0_y(i_vertex0_y), .i_vertex0_z(i_vertex0_z),
        .i_vertex1_x(i_vertex1_x), .i_vertex1_y(i_vertex1_y), .i_vertex1_z(i_vertex1_z),
        .i_vertex2_x(i_vertex2_x), .i_vertex2_y(i_vertex2_y), .i_vertex2_z(i_vertex2_z),
        .i_point_x(i_point_x), .i_point_y(i_point_y), .i_point_z(i_point_z),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_weight0(o_weight0), .o_weight1(o_weight1), .o_weight2(o_weight2),
        .o_degenerate(o_degenerate)
    );

    always begin
        i_clk = 1'b0; #4;
        i_clk = 1'b1; #4;
    end

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    task automatic send_query(tri_query_t c);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_vertex0_x <= c[0];  i_vertex0_y <= c[1];  i_vertex0_z <= c[2];
        i_vertex1_x <= c[3];  i_vertex1_y <= c[4];  i_vertex1_z <= c[5];
        i_vertex2_x <= c[6];  i_vertex2_y <= c[7];  i_vertex2_z <= c[8];
        i_point_x   <= c[9];  i_point_y   <= c[10]; i_point_z   <= c[11];
        do @(posedge i_clk); while (!o_ready);
        sb.note_query(c);
        n_sent++;
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    function automatic tri_query_t make_query(coord_t a0, a1, a2, b0, b1, b2,
                                              c0, c1, c2, p0, p1, p2);
        tri_query_t q;
        q = '{a0, a1, a2, b0, b1, b2, c0, c1, c2, p0, p1, p2};
        return q;
    endfunction

    // well-formed triangle around a random center with a nearby point
    function automatic tri_query_t near_query();
        tri_query_t q;
        coord_t ctr[3];
        int spread;
        spread = $urandom_range(3) == 0 ? (1 << 28) : (1 << $urandom_range(4, 22));
        for (int j = 0; j < 3; j++) ctr[j] = $urandom_range(1 << 24) - (1 << 23);
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 3; j++)
                q[i*3+j] = ctr[j] + $signed($urandom_range(2*spread) - spread);
        // sometimes flatten one axis so each projection and ties get exercised
        if ($urandom_range(3) == 0) begin
            int ax;
            ax = $urandom_range(2);
            for (int i = 0; i < 3; i++) q[i*3+ax] = ctr[ax];
        end
        return q;
    endfunction

    function automatic tri_query_t tiny_query();
        tri_query_t q;
        foreach (q[k]) q[k] = $signed($urandom_range(6)) - 3;
        return q;
    endfunction

    function automatic tri_query_t wild_query();
        tri_query_t q;
        foreach (q[k]) q[k] = $urandom;
        return q;
    endfunction

    initial begin
        tri_query_t q;
        int total;
        sb = new();
        n_sent = 0;
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        {i_vertex0_x, i_vertex0_y, i_vertex0_z} <= '0;
        {i_vertex1_x, i_vertex1_y, i_vertex1_z} <= '0;
        {i_vertex2_x, i_vertex2_y, i_vertex2_z} <= '0;
        {i_point_x, i_point_y, i_point_z} <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: degenerate, axis projections, ties, saturation, extremes
        send_query(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_query(make_query(0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE/4, ONE/4, 5));
        send_query(make_query(0, 0, 0, 0, ONE, 0, 0, 0, ONE, 7, ONE/3, ONE/2));
        send_query(make_query(0, 0, 0, 0, 0, ONE, ONE, 0, 0, ONE/5, -3, ONE));
        send_query(make_query(0, 0, 0, 1, -1, 0, 0, 0, 1, 2, 3, 1));
        send_query(make_query(0, 0, 0, 1, 0, 0, 0, 1, 1, 1, 1, 2));
        send_query(make_query(0, 0, 0, 1, 1, 1, 1, 1, 1, 3, 3, 3));
        send_query(make_query(0, 0, 0, ONE, ONE, ONE, 2*ONE, 2*ONE, 2*ONE, 1, 2, 3));
        send_query(make_query(0, 0, 0, 1, 0, 0, 0, 1, 0,
                              32'sh7fffffff, 32'sh7fffffff, 0));
        send_query(make_query(0, 0, 0, 1, 0, 0, 0, 1, 0,
                              32'sh80000000, 32'sh80000000, 0));
        send_query(make_query(0, 0, 0, 1, 0, 0, 0, 1, 0, 32'sh7fffffff, 0, 0));
        send_query(make_query(32'sh80000000, 32'sh80000000, 32'sh80000000,
                              32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                              32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                              32'sh7fffffff, 32'sh7fffffff, 32'sh80000000));
        send_query(make_query(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                              32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                              32'sh7fffffff, 32'sh80000000, 32'sh80000000,
                              0, 0, 0));
        send_query(make_query(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
        send_query(make_query(0, 0, 0, 32'sh7fffffff, 0, 0, 0, 32'sh7fffffff, 0,
                              32'sh80000000, 32'sh7fffffff, 32'sh7fffffff));

        // hold off until the pipe has emptied
        drain_results();

        total = 1835;
        for (int n = 0; n < total; n++) begin
            if (n == total / 3) begin
                snd_idle_pct = 59; rcv_idle_pct = 21;
            end else if (n == 2 * total / 3) begin
                snd_idle_pct = 0; rcv_idle_pct = 0;
            end else if (n == 0) begin
                snd_idle_pct = 21; rcv_idle_pct = 59;
            end
            case ($urandom_range(9))
                0, 1:    q = wild_query();
                2:       q = tiny_query();
                default: q = near_query();
            endcase
            send_query(q);
        end
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("sent %0d triangles, checked %0d weight beats, %0d degenerate, %0d saturated",
                 n_sent, sb.n_checked, sb.n_degen, sb.n_sat);
        $display("mismatches: %0d", sb.n_errors);
        if (sb.n_errors == 0 && sb.pending.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // result side: check the beat taken at this edge, then pick the next ready
    initial begin
        weights_t got;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                got.w0 = o_weight0;
                got.w1 = o_weight1;
                got.w2 = o_weight2;
                got.degen = o_degenerate;
                sb.check_weights(got);
            end
            i_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

endmodule
